// File: hw/rtl/stt_pkg.sv
// Shared types, constants and keyword table for the source text tokenizer.
package stt_pkg;

   // Default counter widths
   localparam int DEF_OFFSET_BITS = 24;
   localparam int DEF_LINE_BITS   = 20;
   localparam int DEF_COLUMN_BITS = 16;
   localparam int DEF_LENGTH_BITS = 16;

   // Token kinds
   localparam logic [5:0] KIND_EOF           = 6'd0;
   localparam logic [5:0] KIND_ERROR         = 6'd1;
   localparam logic [5:0] KIND_COMMENT       = 6'd2;
   localparam logic [5:0] KIND_DOT           = 6'd3;
   localparam logic [5:0] KIND_COMMA         = 6'd4;
   localparam logic [5:0] KIND_LPAREN        = 6'd5;
   localparam logic [5:0] KIND_RPAREN        = 6'd6;
   localparam logic [5:0] KIND_LBRACKET      = 6'd7;
   localparam logic [5:0] KIND_RBRACKET      = 6'd8;
   localparam logic [5:0] KIND_PLUS          = 6'd9;
   localparam logic [5:0] KIND_MINUS         = 6'd10;
   localparam logic [5:0] KIND_STAR          = 6'd11;
   localparam logic [5:0] KIND_SLASH         = 6'd12;
   localparam logic [5:0] KIND_PERCENT       = 6'd13;
   localparam logic [5:0] KIND_EQUAL         = 6'd14;
   localparam logic [5:0] KIND_BANG_EQUAL    = 6'd16;
   localparam logic [5:0] KIND_LESS          = 6'd17;
   localparam logic [5:0] KIND_GREATER       = 6'd19;
   localparam logic [5:0] KIND_COLON         = 6'd21;
   localparam logic [5:0] KIND_CAP_NAME      = 6'd23;
   localparam logic [5:0] KIND_NAME          = 6'd24;
   localparam logic [5:0] KIND_STRING        = 6'd25;
   localparam logic [5:0] KIND_NUMBER        = 6'd26;
   localparam logic [5:0] KIND_KEYWORD_BASE  = 6'd27;

   // Error codes
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_UNEXPECTED   = 3'd1;
   localparam logic [2:0] ERR_BANG         = 3'd2;
   localparam logic [2:0] ERR_MULTI_POINT  = 3'd3;
   localparam logic [2:0] ERR_LEADING_ZERO = 3'd4;
   localparam logic [2:0] ERR_UNTERM_STR   = 3'd5;

   // Characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   // Keyword table, packed big-endian into the low bytes
   localparam int NUM_KEYWORDS = 15;
   localparam logic [63:0] KW_WORD [NUM_KEYWORDS] = '{
      64'h616E64,             // and
      64'h646566,             // def
      64'h656C7365,           // else
      64'h656E64,             // end
      64'h657874656E64,       // extend
      64'h66616C7365,         // false
      64'h666F72,             // for
      64'h6966,               // if
      64'h6D61746368,         // match
      64'h6E6F74,             // not
      64'h6F72,               // or
      64'h70726F746F636F6C,   // protocol
      64'h7265636F7264,       // record
      64'h74727565,           // true
      64'h7768696C65          // while
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd3, 4'd3, 4'd4, 4'd3, 4'd6, 4'd5, 4'd3, 4'd2,
      4'd5, 4'd3, 4'd2, 4'd8, 4'd6, 4'd4, 4'd5
   };

   // Lexer mode
   typedef enum logic [7:0] {
      MODE_IDLE = 8'b0000_0001,
      MODE_NAME = 8'b0000_0010,
      MODE_CAP  = 8'b0000_0100,
      MODE_NUM  = 8'b0000_1000,
      MODE_STR  = 8'b0001_0000,
      MODE_COM  = 8'b0010_0000,
      MODE_OP   = 8'b0100_0000,
      MODE_DROP = 8'b1000_0000
   } lex_mode_type;

   // One result beat
   typedef struct packed {
      logic [5:0]  token_kind;
      logic [2:0]  error_code;
      logic [7:0]  bad_char;
      logic [23:0] start_offset;
      logic [15:0] token_length;
      logic [19:0] line_number;
      logic [15:0] column_number;
      logic        last;
   } rsp_type;

endpackage

// File: hw/rtl/stt_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [2:0]  error_code;
   logic [7:0]  bad_char;
   logic [23:0] start_offset;
   logic [15:0] token_length;
   logic [19:0] line_number;
   logic [15:0] column_number;
   logic        last;
   modport source (output valid, output token_kind, output error_code, output bad_char,
                   output start_offset, output token_length, output line_number,
                   output column_number, output last, input ready);
   modport sink (input valid, input token_kind, input error_code, input bad_char,
                 input start_offset, input token_length, input line_number,
                 input column_number, input last, output ready);
endinterface

// File: hw/rtl/stt_lexer.sv
// Lexer state registers and per-byte token decision logic.
module stt_lexer
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int LINE_BITS   = DEF_LINE_BITS,
   parameter int COLUMN_BITS = DEF_COLUMN_BITS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] ch,
   output rsp_type    res0,
   output rsp_type    res1,
   output logic [1:0] res_count
);

   lex_mode_type            mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]  off_ff, off_in, ts_off_ff, ts_off_in;
   logic [LINE_BITS-1:0]    line_ff, line_in, ts_line_ff, ts_line_in;
   logic [COLUMN_BITS-1:0]  col_ff, col_in, ts_col_ff, ts_col_in;
   logic [LENGTH_BITS-1:0]  len_ff, len_in, len_sat, a_len;
   logic [63:0]             win_ff, win_in;
   logic                    point_ff, point_in, multi_ff, multi_in;
   logic                    bs_ff, bs_in, zero_ff, zero_in;
   logic [7:0]              pend_ff, pend_in;

   logic [OFFSET_BITS-1:0]  cons_off;
   logic [LINE_BITS-1:0]    cons_line;
   logic [COLUMN_BITS-1:0]  cons_col;
   logic                    is_space, is_ident, is_numeral, is_lower, is_upper;
   logic                    a_valid, b_valid, run_idle, do_consume;
   logic [5:0]              a_kind, b_kind, name_kind, one_kind;
   logic [2:0]              a_err, b_err;
   logic [7:0]              a_bad, b_bad;
   rsp_type                 res_a, res_b;

   // Classify the byte
   always_comb begin
      is_space   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
      is_numeral = (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_lower   = (ch >= CH_LO_A) && (ch <= CH_LO_Z);
      is_upper   = (ch >= CH_UP_A) && (ch <= CH_UP_Z);
      is_ident   = is_numeral || is_lower || is_upper || (ch == CH_UNDER);
   end

   // Position counters after this byte, saturating
   always_comb begin
      cons_off = (off_ff == '1) ? off_ff : off_ff + 1'b1;
      len_sat  = (len_ff == '1) ? len_ff : len_ff + 1'b1;
      if (ch == CH_LF) begin
         cons_line = (line_ff == '1) ? line_ff : line_ff + 1'b1;
         cons_col  = '0;
      end else begin
         cons_line = line_ff;
         cons_col  = (col_ff == '1) ? col_ff : col_ff + 1'b1;
      end
   end

   // Match the finished name against the keyword table
   always_comb begin
      name_kind = KIND_NAME;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if ((len_ff == LENGTH_BITS'(KW_LEN[i])) && (win_ff == KW_WORD[i])) begin
            name_kind = KIND_KEYWORD_BASE + 6'(i);
         end
      end
      if (mode_ff == MODE_CAP) begin
         name_kind = KIND_CAP_NAME;
      end
   end

   // Single-character kind of the pending operator
   always_comb begin
      case (pend_ff)
         CH_EQUAL: one_kind = KIND_EQUAL;
         CH_LESS:  one_kind = KIND_LESS;
         CH_GREAT: one_kind = KIND_GREATER;
         default:  one_kind = KIND_COLON;
      endcase
   end

   // Next state and results
   always_comb begin
      mode_in    = mode_ff;
      off_in     = off_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      ts_off_in  = ts_off_ff;
      ts_line_in = ts_line_ff;
      ts_col_in  = ts_col_ff;
      len_in     = len_ff;
      win_in     = win_ff;
      point_in   = point_ff;
      multi_in   = multi_ff;
      bs_in      = bs_ff;
      zero_in    = zero_ff;
      pend_in    = pend_ff;
      a_valid    = 1'b0;
      a_kind     = KIND_EOF;
      a_err      = ERR_NONE;
      a_bad      = 8'd0;
      a_len      = len_ff;
      b_valid    = 1'b0;
      b_kind     = KIND_EOF;
      b_err      = ERR_NONE;
      b_bad      = 8'd0;
      run_idle   = 1'b0;
      do_consume = 1'b0;

      // Continue the token in progress
      case (mode_ff)
         MODE_NAME, MODE_CAP: begin
            if (is_ident) begin
               do_consume = 1'b1;
               len_in     = len_sat;
               win_in     = {win_ff[55:0], ch};
            end else begin
               a_valid  = 1'b1;
               a_kind   = name_kind;
               run_idle = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_numeral || (ch == CH_DOT)) begin
               if (ch == CH_DOT) begin
                  multi_in = multi_ff | point_ff;
                  point_in = 1'b1;
               end
               do_consume = 1'b1;
               len_in     = len_sat;
            end else begin
               a_valid  = 1'b1;
               run_idle = 1'b1;
               if (zero_ff && (len_ff > LENGTH_BITS'(1))) begin
                  a_kind = KIND_ERROR;
                  a_err  = ERR_LEADING_ZERO;
               end else if (multi_ff) begin
                  a_kind = KIND_ERROR;
                  a_err  = ERR_MULTI_POINT;
               end else begin
                  a_kind = KIND_NUMBER;
               end
            end
         end
         MODE_STR: begin
            if (ch == CH_NUL) begin
               a_valid  = 1'b1;
               a_kind   = KIND_ERROR;
               a_err    = ERR_UNTERM_STR;
               run_idle = 1'b1;
            end else begin
               do_consume = 1'b1;
               len_in     = len_sat;
               if ((ch == CH_QUOTE) && !bs_ff) begin
                  mode_in = MODE_IDLE;
                  a_valid = 1'b1;
                  a_kind  = KIND_STRING;
                  a_len   = len_sat;
               end else begin
                  bs_in = (ch == CH_BSLASH);
               end
            end
         end
         MODE_COM: begin
            if ((ch != CH_LF) && (ch != CH_NUL)) begin
               do_consume = 1'b1;
               len_in     = len_sat;
            end else begin
               a_valid  = 1'b1;
               a_kind   = KIND_COMMENT;
               run_idle = 1'b1;
            end
         end
         MODE_OP: begin
            if (ch == CH_EQUAL) begin
               do_consume = 1'b1;
               len_in     = LENGTH_BITS'(2);
               a_len      = LENGTH_BITS'(2);
               mode_in    = MODE_IDLE;
               a_valid    = 1'b1;
               a_kind     = (pend_ff == CH_BANG) ? KIND_BANG_EQUAL : one_kind + 6'd1;
            end else if (pend_ff == CH_BANG) begin
               a_valid = 1'b1;
               a_kind  = KIND_ERROR;
               a_err   = ERR_BANG;
               a_bad   = ch;
               if (ch == CH_NUL) begin
                  run_idle = 1'b1;
               end else begin
                  do_consume = 1'b1;
                  mode_in    = is_space ? MODE_DROP : MODE_IDLE;
               end
            end else begin
               a_valid  = 1'b1;
               a_kind   = one_kind;
               run_idle = 1'b1;
            end
         end
         MODE_DROP: begin
            if (ch == CH_NUL) begin
               run_idle = 1'b1;
            end else begin
               do_consume = 1'b1;
               if (!is_space) begin
                  mode_in = MODE_IDLE;
               end
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      // Advance positions for a consumed byte
      if (do_consume || run_idle) begin
         off_in  = cons_off;
         line_in = cons_line;
         col_in  = cons_col;
      end

      // Start a new token from idle
      if (run_idle) begin
         mode_in = MODE_IDLE;
         if (!is_space) begin
            ts_off_in  = off_ff;
            ts_line_in = cons_line;
            ts_col_in  = cons_col;
            len_in     = LENGTH_BITS'(1);
            if (is_lower || (ch == CH_UNDER)) begin
               mode_in = MODE_NAME;
               win_in  = 64'(ch);
            end else if (is_upper) begin
               mode_in = MODE_CAP;
               win_in  = 64'(ch);
            end else if (is_numeral) begin
               mode_in  = MODE_NUM;
               point_in = 1'b0;
               multi_in = 1'b0;
               zero_in  = (ch == CH_ZERO);
            end else begin
               case (ch)
                  CH_DOT:   begin b_valid = 1'b1; b_kind = KIND_DOT;      end
                  CH_COMMA: begin b_valid = 1'b1; b_kind = KIND_COMMA;    end
                  CH_LPAR:  begin b_valid = 1'b1; b_kind = KIND_LPAREN;   end
                  CH_RPAR:  begin b_valid = 1'b1; b_kind = KIND_RPAREN;   end
                  CH_LBRK:  begin b_valid = 1'b1; b_kind = KIND_LBRACKET; end
                  CH_RBRK:  begin b_valid = 1'b1; b_kind = KIND_RBRACKET; end
                  CH_PLUS:  begin b_valid = 1'b1; b_kind = KIND_PLUS;     end
                  CH_MINUS: begin b_valid = 1'b1; b_kind = KIND_MINUS;    end
                  CH_STAR:  begin b_valid = 1'b1; b_kind = KIND_STAR;     end
                  CH_SLASH: begin b_valid = 1'b1; b_kind = KIND_SLASH;    end
                  CH_PCT:   begin b_valid = 1'b1; b_kind = KIND_PERCENT;  end
                  CH_EQUAL, CH_BANG, CH_LESS, CH_GREAT, CH_COLON: begin
                     mode_in = MODE_OP;
                     pend_in = ch;
                  end
                  CH_QUOTE: begin
                     mode_in = MODE_STR;
                     bs_in   = 1'b0;
                  end
                  CH_HASH: begin
                     mode_in = MODE_COM;
                  end
                  CH_NUL: begin
                     b_valid = 1'b1;
                     b_kind  = KIND_EOF;
                  end
                  default: begin
                     b_valid = 1'b1;
                     b_kind  = KIND_ERROR;
                     b_err   = ERR_UNEXPECTED;
                     b_bad   = ch;
                  end
               endcase
            end
         end
      end

      // Build results before end of text clears the state
      res_a = '{a_kind, a_err, a_bad, 24'(ts_off_ff), 16'(a_len), 20'(ts_line_ff),
                16'(ts_col_ff), 1'b0};
      res_b = '{b_kind, b_err, b_bad, 24'(ts_off_in), 16'(len_in), 20'(ts_line_in),
                16'(ts_col_in), 1'b1};

      // Restart after end of text
      if (run_idle && (ch == CH_NUL)) begin
         mode_in    = MODE_IDLE;
         off_in     = '0;
         line_in    = LINE_BITS'(1);
         col_in     = '0;
         ts_off_in  = '0;
         ts_line_in = LINE_BITS'(1);
         ts_col_in  = '0;
         len_in     = '0;
         win_in     = '0;
         point_in   = 1'b0;
         multi_in   = 1'b0;
         bs_in      = 1'b0;
         zero_in    = 1'b0;
         pend_in    = 8'd0;
      end
   end

   // Order the results, last flag on the final one
   always_comb begin
      res_count = {1'b0, accept & a_valid} + {1'b0, accept & b_valid};
      res1      = res_b;
      if (a_valid) begin
         res0      = res_a;
         res0.last = !b_valid;
      end else begin
         res0 = res_b;
      end
   end

   // Hold lexer state, update on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         off_ff     <= '0;
         line_ff    <= LINE_BITS'(1);
         col_ff     <= '0;
         ts_off_ff  <= '0;
         ts_line_ff <= LINE_BITS'(1);
         ts_col_ff  <= '0;
         len_ff     <= '0;
         win_ff     <= '0;
         point_ff   <= 1'b0;
         multi_ff   <= 1'b0;
         bs_ff      <= 1'b0;
         zero_ff    <= 1'b0;
         pend_ff    <= 8'd0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         off_ff     <= off_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         ts_off_ff  <= ts_off_in;
         ts_line_ff <= ts_line_in;
         ts_col_ff  <= ts_col_in;
         len_ff     <= len_in;
         win_ff     <= win_in;
         point_ff   <= point_in;
         multi_ff   <= multi_in;
         bs_ff      <= bs_in;
         zero_ff    <= zero_in;
         pend_ff    <= pend_in;
      end
   end

   // End of text always returns to idle, offset and column cleared, line reset to 1
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && (ch == CH_NUL)) |=> (mode_ff == MODE_IDLE) && (off_ff == '0))
      else $error("lexer did not restart after end of text");

   // A string closes only on an unescaped quote
   a_str_close: assert property (@(posedge clock) disable iff (reset)
      (accept && (mode_ff == MODE_STR) && bs_ff && (ch == CH_QUOTE)) |=> (mode_ff == MODE_STR))
      else $error("escaped quote closed a string");

   // Name tokens always carry a nonzero length
   a_name_len: assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_NAME) || (mode_ff == MODE_CAP)) |-> (len_ff != '0))
      else $error("name token with zero length");

endmodule

// File: hw/rtl/stt_rsp_fifo.sv
// Four-entry result queue taking up to two beats per cycle.
module stt_rsp_fifo
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    push0,
   input  rsp_type    push1,
   output logic       room,
   output logic       head_valid,
   output rsp_type    head,
   input  logic       pop
);

   localparam int DEPTH = 4;

   rsp_type    mem_ff [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] count_ff, count_in;

   // Report space for a full two-beat push
   always_comb begin
      room       = (count_ff <= 3'(DEPTH - 2));
      head_valid = (count_ff != 3'd0);
      head       = mem_ff[rd_ff];
      wr_in      = wr_ff + push_count;
      rd_in      = rd_ff + {1'b0, pop};
      count_in   = count_ff + {1'b0, push_count} - {2'b00, pop};
   end

   // Store pushed beats
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ff + 2'd1] <= push1;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> room)
      else $error("push without room");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

// File: hw/rtl/source_text_tokenizer_unit.sv
// Source text tokenizer: one byte in, up to two tokens out per byte.
// Each token is written into the result queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while the result queue has room; a byte ending
//   two tokens yields two beats, sent on the one-beat-per-cycle result port.
// Input is taken while the four-entry result queue has room for two beats.
// Synchronous reset returns to idle, line 1, column 0, offset 0, queue empty.
module source_text_tokenizer_unit
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int LINE_BITS   = DEF_LINE_BITS,
   parameter int COLUMN_BITS = DEF_COLUMN_BITS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
)(
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req_port,
   stt_rsp_if.source rsp_port
);

   logic       accept, room, head_valid;
   logic [1:0] res_count;
   rsp_type    res0, res1, head;

   assign req_port.ready = room;
   assign accept         = req_port.valid && room;

   stt_lexer #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ch        (req_port.ch),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   stt_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push0      (res0),
      .push1      (res1),
      .room       (room),
      .head_valid (head_valid),
      .head       (head),
      .pop        (head_valid && rsp_port.ready)
   );

   // Drive the result beat
   assign rsp_port.valid         = head_valid;
   assign rsp_port.token_kind    = head.token_kind;
   assign rsp_port.error_code    = head.error_code;
   assign rsp_port.bad_char      = head.bad_char;
   assign rsp_port.start_offset  = head.start_offset;
   assign rsp_port.token_length  = head.token_length;
   assign rsp_port.line_number   = head.line_number;
   assign rsp_port.column_number = head.column_number;
   assign rsp_port.last          = head.last;

endmodule
